[rtl/i2cseq_pkg.sv]
// Types, codes and result helpers shared by the I2C slave byte sequencer.
package i2cseq_pkg;

    // Widths of the beat fields
    localparam int FUNC_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int BITS_W   = 4;
    localparam int ADDR_W   = 7;
    localparam int REGIDX_W = 2;
    localparam int CFGDAT_W = 7;

    // Byte constants
    localparam logic [BYTE_W-1:0] LOAD_PAD  = 8'hFF;
    localparam logic [BYTE_W-1:0] LOAD_ZERO = 8'h00;
    localparam logic [BYTE_W-1:0] GEN_CALL  = 8'h00;

    // Bit counts handed to the serial unit
    localparam logic [BITS_W-1:0] BITS_NONE = 4'd0;
    localparam logic [BITS_W-1:0] BITS_ONE  = 4'd1;
    localparam logic [BITS_W-1:0] BITS_BYTE = 4'd8;

    // Event codes
    typedef enum logic [FUNC_W-1:0] {
        FN_START    = 2'd0,
        FN_OVERFLOW = 2'd1,
        FN_TRANSMIT = 2'd2,
        FN_RESPOND  = 2'd3
    } t_func;

    // Configuration register indexes
    typedef enum logic [REGIDX_W-1:0] {
        REG_SLAVE_EN = 2'd0,
        REG_OWN_ADDR = 2'd1,
        REG_GC_EN    = 2'd2
    } t_reg_idx;

    // Status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_IDLE   = 3'd0,
        ST_BUSY   = 3'd1,
        ST_NEEDTX = 3'd2,
        ST_RXED   = 3'd3,
        ST_ERROR  = 3'd4
    } t_status;

    // Bus phase
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ADDR_RX = 3'd1,
        PH_RX_ACKD = 3'd2,
        PH_RX_DONE = 3'd3,
        PH_TX_ACKD = 3'd4,
        PH_TX_WAIT = 3'd5,
        PH_TX_DONE = 3'd6
    } t_phase;

    // Drive fields of one result beat
    typedef struct packed {
        t_status           status;
        logic [BYTE_W-1:0] shift_load;
        logic              sda_drive;
        logic [BITS_W-1:0] bit_count;
        logic              overflow_enable;
        logic              start_wait;
    } t_result;

    // Drive the serial unit with a byte to shift out
    function automatic t_result res_shift_out(input logic [BYTE_W-1:0] data,
                                              input logic [BITS_W-1:0] bits);
        t_result r;
        r = '{status: ST_BUSY, shift_load: data, sda_drive: 1'b1,
              bit_count: bits, overflow_enable: 1'b1, start_wait: 1'b0};
        return r;
    endfunction

    // Arm the serial unit to shift bits in
    function automatic t_result res_shift_in(input logic [BITS_W-1:0] bits);
        t_result r;
        r = '{status: ST_BUSY, shift_load: LOAD_ZERO, sda_drive: 1'b0,
              bit_count: bits, overflow_enable: 1'b1, start_wait: 1'b0};
        return r;
    endfunction

    // Hold SCL low with the given status
    function automatic t_result res_stretch(input t_status st);
        t_result r;
        r = '{status: st, shift_load: LOAD_ZERO, sda_drive: 1'b0,
              bit_count: BITS_NONE, overflow_enable: 1'b0, start_wait: 1'b0};
        return r;
    endfunction

    // Drop back to waiting for a start condition
    function automatic t_result res_wait_start();
        t_result r;
        r = '{status: ST_IDLE, shift_load: LOAD_ZERO, sda_drive: 1'b0,
              bit_count: BITS_NONE, overflow_enable: 1'b0, start_wait: 1'b1};
        return r;
    endfunction

endpackage

[rtl/i2cseq_if.sv]
// Channel interfaces of the I2C slave byte sequencer: events, results, register writes.
interface i2cseq_in_if;
    logic                           valid;
    logic                           ready;
    logic [i2cseq_pkg::FUNC_W-1:0]  func;
    logic [i2cseq_pkg::BYTE_W-1:0]  shift_data;
    logic [i2cseq_pkg::BYTE_W-1:0]  tx_byte;
    logic                           tx_last;
    logic                           respond_nack;

    modport source (output valid, func, shift_data, tx_byte, tx_last, respond_nack,
                    input ready);
    modport sink   (input valid, func, shift_data, tx_byte, tx_last, respond_nack,
                    output ready);
endinterface

interface i2cseq_out_if;
    logic                             valid;
    logic                             ready;
    logic [i2cseq_pkg::STATUS_W-1:0]  status;
    logic [i2cseq_pkg::BYTE_W-1:0]    shift_load;
    logic                             sda_drive;
    logic [i2cseq_pkg::BITS_W-1:0]    bit_count;
    logic                             overflow_enable;
    logic                             start_wait;
    logic [i2cseq_pkg::BYTE_W-1:0]    received_byte;

    modport source (output valid, status, shift_load, sda_drive, bit_count,
                    overflow_enable, start_wait, received_byte, input ready);
    modport sink   (input valid, status, shift_load, sda_drive, bit_count,
                    overflow_enable, start_wait, received_byte, output ready);
endinterface

interface i2cseq_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [i2cseq_pkg::REGIDX_W-1:0]  reg_index;
    logic [i2cseq_pkg::CFGDAT_W-1:0]  wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

[rtl/i2c_slave_byte_sequencer.sv]
// Top level of the I2C slave byte sequencer: event register, sequencing logic, result register.
//
//  Port    Dir  Beat contents
//  i_in    in   func, shift_data, tx_byte, tx_last, respond_nack
//  o_out   out  status, shift_load, sda_drive, bit_count, overflow_enable,
//               start_wait, received_byte
//  i_cfg   in   reg_index, wr_data (slave_enable, own_address, general_call_enable)
//
//  One event per cycle while o_out is not held off; an event's result beat passes
//  through the event register and then the result register before it is valid on o_out.
//  The event register and the result register form two slots, so an event is
//  taken while a finished result still waits on o_out; i_in stalls only when both
//  slots are full and o_out is held off.
//  Phase, last-byte flag and received byte advance when an event moves into the
//  result register. Register writes are taken whenever offered; i_cfg.ready is always high.
//  Synchronous active-low reset clears the slot valid flags, sequencer state and config registers.
module i2c_slave_byte_sequencer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    i2cseq_in_if.sink    i_in,
    i2cseq_out_if.source o_out,
    i2cseq_cfg_if.sink   i_cfg
);
    import i2cseq_pkg::*;

    // Configuration registers
    logic              r_slave_en;
    logic [ADDR_W-1:0] r_own_addr;
    logic              r_gc_en;

    // Event register
    logic              r_in_valid;
    t_func             r_in_func;
    logic [BYTE_W-1:0] r_in_shift_data;
    logic [BYTE_W-1:0] r_in_tx_byte;
    logic              r_in_tx_last;
    logic              r_in_nack;

    // Sequencer state
    t_phase            r_phase,   n_phase;
    logic              r_last_tx, n_last_tx;
    logic [BYTE_W-1:0] r_rx_latch, n_rx_latch;

    // Result register
    logic              r_out_valid;
    t_result           r_out,     n_out;
    logic [BYTE_W-1:0] r_out_rx;

    logic              in_acc;
    logic              advance;
    logic              addressed;

    assign advance = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_acc = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // Take register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_en <= 1'b0;
            r_own_addr <= '0;
            r_gc_en    <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                REG_SLAVE_EN: r_slave_en <= i_cfg.wr_data[0];
                REG_OWN_ADDR: r_own_addr <= i_cfg.wr_data[ADDR_W-1:0];
                REG_GC_EN:    r_gc_en    <= i_cfg.wr_data[0];
                default: ;
            endcase
        end
    end

    // Hold the event until the result slot frees
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_func       <= t_func'(i_in.func);
            r_in_shift_data <= i_in.shift_data;
            r_in_tx_byte    <= i_in.tx_byte;
            r_in_tx_last    <= i_in.tx_last;
            r_in_nack       <= i_in.respond_nack;
        end
    end

    // Address match on bits 7 to 1, or general call on byte zero when enabled
    assign addressed = (r_in_shift_data[BYTE_W-1:1] == r_own_addr) ||
                       (r_gc_en && (r_in_shift_data == GEN_CALL));

    // Work out next state and the result beat
    always_comb begin
        n_phase    = r_phase;
        n_last_tx  = r_last_tx;
        n_rx_latch = r_rx_latch;
        n_out      = res_stretch(ST_IDLE);
        if (r_slave_en) begin
            unique case (r_in_func)
                FN_START: begin
                    n_last_tx = 1'b0;
                    n_phase   = PH_ADDR_RX;
                    n_out     = res_shift_in(BITS_BYTE);
                end
                FN_OVERFLOW: begin
                    n_rx_latch = r_in_shift_data;
                    unique case (r_phase)
                        PH_IDLE: begin
                            n_phase = PH_IDLE;
                            n_out   = res_wait_start();
                        end
                        PH_ADDR_RX: begin
                            if (addressed) begin
                                n_phase = r_in_shift_data[0] ? PH_TX_WAIT : PH_RX_ACKD;
                                n_out   = res_shift_out(LOAD_ZERO, BITS_ONE);
                            end else begin
                                n_phase = PH_IDLE;
                                n_out   = res_wait_start();
                            end
                        end
                        PH_RX_ACKD: begin
                            n_phase = PH_RX_DONE;
                            n_out   = res_shift_in(BITS_BYTE);
                        end
                        PH_TX_DONE: begin
                            n_phase = PH_TX_ACKD;
                            n_out   = res_shift_in(BITS_ONE);
                        end
                        PH_TX_ACKD, PH_TX_WAIT: begin
                            // Master nack ends the transmit; otherwise pad or ask the user
                            if (r_phase == PH_TX_ACKD && r_in_shift_data[0]) begin
                                n_phase = PH_IDLE;
                                n_out   = res_wait_start();
                            end else if (r_last_tx) begin
                                n_phase = PH_TX_DONE;
                                n_out   = res_shift_out(LOAD_PAD, BITS_BYTE);
                            end else begin
                                n_phase = PH_TX_WAIT;
                                n_out   = res_stretch(ST_NEEDTX);
                            end
                        end
                        PH_RX_DONE: begin
                            n_out = res_stretch(ST_RXED);
                        end
                        default: begin
                            n_out = res_stretch(ST_ERROR);
                        end
                    endcase
                end
                FN_TRANSMIT: begin
                    n_last_tx = r_in_tx_last;
                    n_phase   = PH_TX_DONE;
                    n_out     = res_shift_out(r_in_tx_byte, BITS_BYTE);
                end
                FN_RESPOND: begin
                    if (r_in_nack) begin
                        n_phase = PH_IDLE;
                        n_out   = res_shift_out(LOAD_PAD, BITS_ONE);
                    end else begin
                        n_phase = PH_RX_ACKD;
                        n_out   = res_shift_out(LOAD_ZERO, BITS_ONE);
                    end
                end
                default: ;
            endcase
        end
    end

    // Advance the state with each event that moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_last_tx  <= 1'b0;
            r_rx_latch <= '0;
        end else if (advance) begin
            r_phase    <= n_phase;
            r_last_tx  <= n_last_tx;
            r_rx_latch <= n_rx_latch;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out    <= n_out;
            r_out_rx <= n_rx_latch;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out.status;
    assign o_out.shift_load      = r_out.shift_load;
    assign o_out.sda_drive       = r_out.sda_drive;
    assign o_out.bit_count       = r_out.bit_count;
    assign o_out.overflow_enable = r_out.overflow_enable;
    assign o_out.start_wait      = r_out.start_wait;
    assign o_out.received_byte   = r_out_rx;

    // A start on an enabled slave always moves to address reception
    a_start_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_slave_en && r_in_func == FN_START |=> r_phase == PH_ADDR_RX)
        else $error("start did not enter address phase");

    // A disabled slave leaves the phase untouched
    a_disabled_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_slave_en |=> $stable(r_phase))
        else $error("phase moved while slave disabled");

    // Shift load is zero unless SDA is driven
    a_load_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.sda_drive |-> r_out.shift_load == LOAD_ZERO)
        else $error("shift load set while SDA is input");

    // Waiting for start means idle status and no bits armed
    a_start_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.start_wait |->
            r_out.status == ST_IDLE && r_out.bit_count == BITS_NONE &&
            !r_out.overflow_enable)
        else $error("start wait with bits armed");

    // A result only ever follows a held event
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid && !r_in_valid |=> !r_out_valid)
        else $error("result without event");

endmodule

[tb/i2cseq_checker.sv]
`timescale 1ns / 100ps
// Result checker for the I2C slave byte sequencer: tracks bus state, predicts and compares beats.
module i2cseq_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    i2cseq_in_if  i_ev,
    i2cseq_out_if i_res,
    i2cseq_cfg_if i_cfg,
    output int    o_fail_count,
    output int    o_beats_owed
);
    import i2cseq_pkg::*;

    localparam int REPORT_MAX = 10;

    // One result beat as the serial unit sees it
    typedef struct packed {
        t_status           status;
        logic [BYTE_W-1:0] shift_load;
        logic              sda_drive;
        logic [BITS_W-1:0] bit_count;
        logic              overflow_enable;
        logic              start_wait;
        logic [BYTE_W-1:0] received_byte;
    } t_drive;

    // Own copy of the registers and the bus state
    logic              slave_en;
    logic [ADDR_W-1:0] own_addr;
    logic              gc_en;
    t_phase            phase_now;
    logic              last_tx;
    logic [BYTE_W-1:0] rx_byte;

    t_drive drives_due[$];
    t_drive want;
    t_drive got;
    int     fails   = 0;
    int     beat_no = 0;

    function automatic t_drive drive_word(input t_status st, input logic [BYTE_W-1:0] load,
                                          input logic drv, input logic [BITS_W-1:0] bits,
                                          input logic ovf, input logic swait);
        t_drive d;
        d.status          = st;
        d.shift_load      = load;
        d.sda_drive       = drv;
        d.bit_count       = bits;
        d.overflow_enable = ovf;
        d.start_wait      = swait;
        d.received_byte   = LOAD_ZERO;
        return d;
    endfunction

    // Advance the bus state by one event and work out the beat it causes
    function automatic t_drive sequence_event(input t_func fn, input logic [BYTE_W-1:0] sdata,
                                              input logic [BYTE_W-1:0] txb, input logic txl,
                                              input logic nack);
        t_drive d;
        logic   want_byte;
        want_byte = 1'b0;
        d = drive_word(ST_IDLE, LOAD_ZERO, 1'b0, BITS_NONE, 1'b0, 1'b0);
        if (slave_en) begin
            case (fn)
                FN_START: begin
                    last_tx   = 1'b0;
                    phase_now = PH_ADDR_RX;
                    d = drive_word(ST_BUSY, LOAD_ZERO, 1'b0, BITS_BYTE, 1'b1, 1'b0);
                end
                FN_OVERFLOW: begin
                    rx_byte = sdata;
                    case (phase_now)
                        PH_IDLE: begin
                            d = drive_word(ST_IDLE, LOAD_ZERO, 1'b0, BITS_NONE, 1'b0, 1'b1);
                        end
                        PH_ADDR_RX: begin
                            // Own address on bits 7..1, or general call when enabled
                            if (sdata[7:1] == own_addr || (gc_en && sdata == GEN_CALL)) begin
                                phase_now = sdata[0] ? PH_TX_WAIT : PH_RX_ACKD;
                                d = drive_word(ST_BUSY, LOAD_ZERO, 1'b1, BITS_ONE, 1'b1, 1'b0);
                            end else begin
                                phase_now = PH_IDLE;
                                d = drive_word(ST_IDLE, LOAD_ZERO, 1'b0, BITS_NONE, 1'b0, 1'b1);
                            end
                        end
                        PH_RX_ACKD: begin
                            phase_now = PH_RX_DONE;
                            d = drive_word(ST_BUSY, LOAD_ZERO, 1'b0, BITS_BYTE, 1'b1, 1'b0);
                        end
                        PH_RX_DONE: begin
                            d = drive_word(ST_RXED, LOAD_ZERO, 1'b0, BITS_NONE, 1'b0, 1'b0);
                        end
                        PH_TX_DONE: begin
                            phase_now = PH_TX_ACKD;
                            d = drive_word(ST_BUSY, LOAD_ZERO, 1'b0, BITS_ONE, 1'b1, 1'b0);
                        end
                        PH_TX_ACKD: begin
                            // Master nack ends the transmit
                            if (sdata[0]) begin
                                phase_now = PH_IDLE;
                                d = drive_word(ST_IDLE, LOAD_ZERO, 1'b0, BITS_NONE, 1'b0, 1'b1);
                            end else begin
                                want_byte = 1'b1;
                            end
                        end
                        PH_TX_WAIT: begin
                            want_byte = 1'b1;
                        end
                        default: begin
                            d = drive_word(ST_ERROR, LOAD_ZERO, 1'b0, BITS_NONE, 1'b0, 1'b0);
                        end
                    endcase
                    // Pad after the last byte, else stretch for the next one
                    if (want_byte) begin
                        if (last_tx) begin
                            phase_now = PH_TX_DONE;
                            d = drive_word(ST_BUSY, LOAD_PAD, 1'b1, BITS_BYTE, 1'b1, 1'b0);
                        end else begin
                            phase_now = PH_TX_WAIT;
                            d = drive_word(ST_NEEDTX, LOAD_ZERO, 1'b0, BITS_NONE, 1'b0, 1'b0);
                        end
                    end
                end
                FN_TRANSMIT: begin
                    last_tx   = txl;
                    phase_now = PH_TX_DONE;
                    d = drive_word(ST_BUSY, txb, 1'b1, BITS_BYTE, 1'b1, 1'b0);
                end
                default: begin
                    phase_now = nack ? PH_IDLE : PH_RX_ACKD;
                    d = drive_word(ST_BUSY, nack ? LOAD_PAD : LOAD_ZERO, 1'b1, BITS_ONE,
                                   1'b1, 1'b0);
                end
            endcase
        end
        d.received_byte = rx_byte;
        return d;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            slave_en  = 1'b0;
            own_addr  = '0;
            gc_en     = 1'b0;
            phase_now = PH_IDLE;
            last_tx   = 1'b0;
            rx_byte   = LOAD_ZERO;
            drives_due.delete();
        end else begin
            // Compare a result beat with the oldest prediction
            if (i_res.valid && i_res.ready) begin
                got.status          = t_status'(i_res.status);
                got.shift_load      = i_res.shift_load;
                got.sda_drive       = i_res.sda_drive;
                got.bit_count       = i_res.bit_count;
                got.overflow_enable = i_res.overflow_enable;
                got.start_wait      = i_res.start_wait;
                got.received_byte   = i_res.received_byte;
                if (drives_due.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_MAX)
                        $display("beat %0d: result with nothing predicted", beat_no);
                end else begin
                    want = drives_due.pop_front();
                    if (got.status !== want.status || got.shift_load !== want.shift_load ||
                        got.sda_drive !== want.sda_drive || got.bit_count !== want.bit_count ||
                        got.overflow_enable !== want.overflow_enable ||
                        got.start_wait !== want.start_wait ||
                        got.received_byte !== want.received_byte) begin
                        fails++;
                        if (fails <= REPORT_MAX) begin
                            $display("beat %0d: exp st=%0d ld=%02h drv=%0b bits=%0d ovf=%0b sw=%0b rx=%02h",
                                     beat_no, want.status, want.shift_load, want.sda_drive,
                                     want.bit_count, want.overflow_enable, want.start_wait,
                                     want.received_byte);
                            $display("beat %0d: got st=%0d ld=%02h drv=%0b bits=%0d ovf=%0b sw=%0b rx=%02h",
                                     beat_no, got.status, got.shift_load, got.sda_drive,
                                     got.bit_count, got.overflow_enable, got.start_wait,
                                     got.received_byte);
                        end
                    end
                end
                beat_no++;
            end

            // Register writes
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.reg_index)
                    REG_SLAVE_EN: slave_en = i_cfg.wr_data[0];
                    REG_OWN_ADDR: own_addr = i_cfg.wr_data[ADDR_W-1:0];
                    REG_GC_EN:    gc_en    = i_cfg.wr_data[0];
                    default:      ;
                endcase
            end

            // Predict the beat of each accepted event
            if (i_ev.valid && i_ev.ready)
                drives_due.push_back(sequence_event(t_func'(i_ev.func), i_ev.shift_data,
                                                    i_ev.tx_byte, i_ev.tx_last,
                                                    i_ev.respond_nack));
        end
        o_fail_count <= fails;
        o_beats_owed <= drives_due.size();
    end

endmodule

[tb/tb_i2c_slave_byte_sequencer.sv]
`timescale 1ns / 100ps
// Testbench top for the I2C slave byte sequencer: bus-event stimulus, sink stalls and verdict.
module tb_i2c_slave_byte_sequencer;
    import i2cseq_pkg::*;

    localparam int ITEMS_WANTED  = 900;
    localparam int PHASE_QUOTA   = 150;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [REGIDX_W-1:0] REG_SPARE = 2'd3;

    logic i_clk;
    logic i_rst_n;

    i2cseq_in_if  ev_ch ();
    i2cseq_out_if res_ch ();
    i2cseq_cfg_if cfg_ch ();

    int  fail_count;
    int  beats_owed;
    int  items_sent  = 0;
    bit  quiet       = 1'b0;
    bit  steady_sink = 1'b0;
    bit  hold_req    = 1'b0;
    bit  dev_enabled = 1'b0;
    bit  gc_on       = 1'b0;
    logic [ADDR_W-1:0] own = '0;

    i2c_slave_byte_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (ev_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    i2cseq_checker u_result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ev         (ev_ch),
        .i_res        (res_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_beats_owed (beats_owed)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one event beat and hold it until taken
    task automatic send_event(input t_func fn, input logic [BYTE_W-1:0] sdata,
                              input logic [BYTE_W-1:0] txb, input logic txl,
                              input logic nack);
        int gap;
        gap = pick_gap(quiet);
        if (gap > 0) begin
            ev_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        ev_ch.valid        <= 1'b1;
        ev_ch.func         <= fn;
        ev_ch.shift_data   <= sdata;
        ev_ch.tx_byte      <= txb;
        ev_ch.tx_last      <= txl;
        ev_ch.respond_nack <= nack;
        do @(posedge i_clk); while (!ev_ch.ready);
        if (dev_enabled)
            items_sent++;
    endtask

    task automatic ev_start();
        send_event(FN_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic ev_shift(input logic [BYTE_W-1:0] sdata);
        send_event(FN_OVERFLOW, sdata, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    endtask

    task automatic ev_transmit(input logic [BYTE_W-1:0] txb, input logic txl);
        send_event(FN_TRANSMIT, 8'($urandom_range(0, 255)), txb, txl,
                   1'($urandom_range(0, 1)));
    endtask

    task automatic ev_respond(input logic nack);
        send_event(FN_RESPOND, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), nack);
    endtask

    task automatic ev_noise();
        send_event(t_func'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    endtask

    // Hold the sender until every owed result beat is back
    task automatic drain();
        ev_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (beats_owed != 0) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [REGIDX_W-1:0] idx, input logic [CFGDAT_W-1:0] data);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wr_data   <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    // Rewrite all registers once the block has gone quiet
    task automatic write_regs(input logic en, input logic [ADDR_W-1:0] addr, input logic gc);
        logic [CFGDAT_W-1:0] junk;
        drain();
        junk = 7'($urandom_range(0, 127));
        put_reg(REG_SLAVE_EN, {junk[CFGDAT_W-1:1], en});
        put_reg(REG_OWN_ADDR, addr);
        junk = 7'($urandom_range(0, 127));
        put_reg(REG_GC_EN, {junk[CFGDAT_W-1:1], gc});
        cfg_ch.valid <= 1'b0;
        dev_enabled = en;
        own         = addr;
        gc_on       = gc;
    endtask

    // One bus transfer: mostly well formed, some noise
    task automatic random_transfer();
        int                r;
        int                n;
        int                k;
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
        logic              txl;
        logic              nack;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            ev_noise();
        end else begin
            ev_start();
            r = $urandom_range(0, 99);
            if (r < 70)
                a = {own, 1'($urandom_range(0, 1))};
            else if (r < 82)
                a = GEN_CALL;
            else
                a = 8'($urandom_range(0, 255));
            ev_shift(a);
            if (a[7:1] == own || (gc_on && a == GEN_CALL)) begin
                // Address ack bit clocked out
                ev_shift(8'($urandom_range(0, 255)));
                n = $urandom_range(1, 4);
                if (!a[0]) begin
                    // Master writes: byte in, user answers, ack bit out
                    for (k = 0; k < n; k++) begin
                        ev_shift(8'($urandom_range(0, 255)));
                        nack = (k == n - 1) && ($urandom_range(0, 2) != 0);
                        ev_respond(nack);
                        if (!nack)
                            ev_shift(8'($urandom_range(0, 255)));
                    end
                end else begin
                    // Master reads: user byte out, master ack bit in
                    for (k = 0; k < n; k++) begin
                        txl = (k == n - 1) && ($urandom_range(0, 1) != 0);
                        ev_transmit(8'($urandom_range(0, 255)), txl);
                        ev_shift(8'($urandom_range(0, 255)));
                        b = 8'($urandom_range(0, 255));
                        b[0] = (k == n - 1) && ($urandom_range(0, 1) != 0);
                        ev_shift(b);
                        if (k == n - 1 && !b[0] && txl) begin
                            ev_shift(8'($urandom_range(0, 255)));
                            b = 8'($urandom_range(0, 255));
                            b[0] = 1'b1;
                            ev_shift(b);
                        end
                    end
                end
            end
        end
    endtask

    // Sink side: random ready, with one long hold-off on request
    initial begin : sink_side
        int run;
        int gap;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                run = $urandom_range(1, 8);
                res_ch.ready <= 1'b1;
                repeat (run) @(posedge i_clk);
                gap = pick_gap(steady_sink);
                if (gap > 0) begin
                    res_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    // Watchdog on cycles with no beat moving anywhere
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((ev_ch.valid && ev_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int ph;
        int target;
        i_rst_n            <= 1'b0;
        ev_ch.valid        <= 1'b0;
        ev_ch.func         <= FN_START;
        ev_ch.shift_data   <= '0;
        ev_ch.tx_byte      <= '0;
        ev_ch.tx_last      <= 1'b0;
        ev_ch.respond_nack <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.reg_index   <= REG_SLAVE_EN;
        cfg_ch.wr_data     <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Disabled: every event ignored; also poke the spare register index
        write_regs(1'b0, 7'h7F, 1'b1);
        put_reg(REG_SPARE, 7'($urandom_range(0, 127)));
        cfg_ch.valid <= 1'b0;
        ev_start();
        ev_shift(8'hFE);
        ev_transmit(8'hFF, 1'b1);
        ev_respond(1'b1);

        // Read from the top address: stretch, bytes, pad after last, master nack
        write_regs(1'b1, 7'h7F, 1'b0);
        ev_shift(8'h00);
        ev_start();
        ev_shift(8'hFF);
        ev_shift(8'h00);
        ev_transmit(8'h00, 1'b0);
        ev_shift(8'h55);
        ev_shift(8'h00);
        ev_transmit(8'hFF, 1'b1);
        ev_shift(8'hAA);
        ev_shift(8'h00);
        ev_shift(8'h00);
        ev_shift(8'h01);

        // Write to the top address: received byte, ack, repeat stretch, nack
        ev_start();
        ev_shift(8'hFE);
        ev_shift(8'hFF);
        ev_shift(8'h3C);
        ev_shift(8'h99);
        ev_respond(1'b0);
        ev_shift(8'h00);
        ev_shift(8'hC3);
        ev_respond(1'b1);

        // Address zero with general call on, read bit on address zero
        write_regs(1'b1, 7'h00, 1'b1);
        ev_start();
        ev_shift(8'h00);
        ev_start();
        ev_shift(8'h01);

        // General call refused when disabled, then a plain read match
        write_regs(1'b1, 7'h12, 1'b0);
        ev_start();
        ev_shift(8'h00);
        ev_start();
        ev_shift(8'h25);

        // Random transfers over several settings
        items_sent = 0;
        for (ph = 0; ph < 7; ph++) begin
            quiet       = 1'b0;
            steady_sink = 1'b0;
            case (ph)
                0: write_regs(1'b1, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
                1: write_regs(1'b1, 7'h00, 1'b1);
                2: write_regs(1'b1, 7'h7F, 1'b0);
                3: write_regs(1'b0, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
                4: write_regs(1'b1, 7'($urandom_range(0, 127)), 1'b1);
                5: write_regs(1'b1, 7'($urandom_range(0, 127)), 1'b0);
                default: write_regs(1'b1, 7'h7F, 1'b1);
            endcase
            if (ph == 1) begin
                // Back-to-back events against a long sink hold-off
                quiet    = 1'b1;
                hold_req = 1'b1;
            end
            if (ph == 2) begin
                quiet       = 1'b1;
                steady_sink = 1'b1;
            end
            if (ph == 3) begin
                repeat (8) random_transfer();
            end else begin
                target = (ph == 6) ? ITEMS_WANTED : items_sent + PHASE_QUOTA;
                while (items_sent < target) random_transfer();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && beats_owed == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
